// ----- src/fbsm_pkg.sv -----
// Shared constants for the flat binary search matrix block.
`default_nettype none

package fbsm_pkg;

    // Default matrix bounds and element width.
    localparam int DEF_MAX_ROWS    = 32;
    localparam int DEF_MAX_COLUMNS = 32;
    localparam int DEF_VALUE_BITS  = 32;

    // Fixed field widths of the stream and configuration ports.
    localparam int COUNT_BITS      = 6;
    localparam int INDEX_BITS      = 10;
    localparam int ITEM_BITS       = 32;
    localparam int POS_BITS        = 5;
    localparam int CFG_INDEX_BITS  = 2;

    // Search range bookkeeping covers the product of two count registers.
    localparam int RANGE_BITS      = 2 * COUNT_BITS;
    localparam int DIV_COUNT_BITS  = $clog2(RANGE_BITS + 1);

    // Packed tdata widths, padded to whole bytes.
    localparam int IN_DATA_BITS    = ((INDEX_BITS + ITEM_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS   = ((2 * POS_BITS + 7) / 8) * 8;

    // Operation codes carried in the input tuser.
    localparam logic OP_LOAD       = 1'b0;
    localparam logic OP_SEARCH     = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_COUNT = 2'd1;

endpackage

`default_nettype wire

// ----- src/flat_binary_search_matrix.sv -----
// Top level of the flat binary search matrix: element store, search sequencer and divider.
`default_nettype none

// A load beat is written into the store at the edge that accepts it; loads go back to back.
// A search beat takes a setup state, then a probe (read) and a compare state per probe for
// at most eleven probes over a 32 by 32 matrix, the divider on a hit or one more probe state on a
// miss, and a finish state that fills the output register when free, input held off meanwhile.
// Reset is asynchronous and active low: both counts return to one; the store is not cleared.
module flat_binary_search_matrix
    import fbsm_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    // Input stream.
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // Bits 9:0 element_index, bits 41:10 item_value, bits 47:42 zero.
    input  wire logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    // Bit 0 operation.
    input  wire logic                      s_axis_tuser,

    // Result stream.
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // Bits 4:0 match_row, bits 9:5 match_column, bits 15:10 zero.
    output logic [OUT_DATA_BITS-1:0]       m_axis_tdata,
    // Bit 0 found.
    output logic                           m_axis_tuser,

    // Configuration write channel.
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [COUNT_BITS-1:0]     cfg_data
);

    localparam int DEPTH      = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SETUP   = 3'd1;
    localparam logic [2:0] ST_PROBE   = 3'd2;
    localparam logic [2:0] ST_COMPARE = 3'd3;
    localparam logic [2:0] ST_DIVIDE  = 3'd4;
    localparam logic [2:0] ST_FINISH  = 3'd5;

    // Incoming fields.
    logic                  in_op;
    logic [INDEX_BITS-1:0] in_index;
    logic [ITEM_BITS-1:0]  in_item;
    logic [VALUE_BITS-1:0] in_value;
    logic                  in_accept;

    assign in_op     = s_axis_tuser;
    assign in_index  = s_axis_tdata[INDEX_BITS-1:0];
    assign in_item   = s_axis_tdata[INDEX_BITS+ITEM_BITS-1:INDEX_BITS];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // The item is taken as a VALUE_BITS wide two's complement value: narrower widths keep
    // the low bits, wider widths zero-extend the 32 bits, as the element format defines.
    generate
        if (VALUE_BITS <= ITEM_BITS) begin : g_value_trunc
            assign in_value = in_item[VALUE_BITS-1:0];
        end
        else begin : g_value_ext
            assign in_value = {{(VALUE_BITS-ITEM_BITS){1'b0}}, in_item};
        end
    endgenerate

    // Configuration registers.
    logic [COUNT_BITS-1:0] row_count_reg, row_count_next;
    logic [COUNT_BITS-1:0] column_count_reg, column_count_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT:    row_count_next    = cfg_data;
                CFG_COLUMN_COUNT: column_count_next = cfg_data;
                default:
                begin
                    row_count_next    = row_count_reg;
                    column_count_next = column_count_reg;
                end
            endcase
        end
    end

    // Counts above the store bounds are clamped to them.
    logic [COUNT_BITS-1:0] rows_eff;
    logic [COUNT_BITS-1:0] cols_eff;

    assign rows_eff = (32'(row_count_reg) > 32'(MAX_ROWS)) ? COUNT_BITS'(MAX_ROWS)
                                                           : row_count_reg;
    assign cols_eff = (32'(column_count_reg) > 32'(MAX_COLUMNS)) ? COUNT_BITS'(MAX_COLUMNS)
                                                                 : column_count_reg;

    // Sequencer and datapath registers. The search keeps an exclusive upper bound, so
    // the classic inclusive bound is end_reg minus one and the loop runs while lo < end.
    logic [2:0]                state_reg, state_next;
    logic [VALUE_BITS-1:0]     key_reg, key_next;
    logic [RANGE_BITS-1:0]     lo_reg, lo_next;
    logic [RANGE_BITS-1:0]     end_reg, end_next;
    logic [RANGE_BITS-1:0]     mid_reg, mid_next;
    logic [COUNT_BITS-1:0]     cols_reg, cols_next;
    logic                      hit_reg, hit_next;
    logic [RANGE_BITS-1:0]     quo_reg, quo_next;
    logic [COUNT_BITS-1:0]     rem_reg, rem_next;
    logic [DIV_COUNT_BITS-1:0] div_cnt_reg, div_cnt_next;

    // Output register.
    logic                      out_valid_reg, out_valid_next;
    logic                      out_found_reg, out_found_next;
    logic [POS_BITS-1:0]       out_row_reg, out_row_next;
    logic [POS_BITS-1:0]       out_col_reg, out_col_next;

    // Element store signals.
    logic [VALUE_BITS-1:0]     mem [DEPTH];
    logic [VALUE_BITS-1:0]     rd_data_reg;
    logic [ADDR_BITS-1:0]      rd_addr;
    logic [ADDR_BITS-1:0]      wr_addr;
    logic                      wr_en;
    logic [ADDR_BITS+INDEX_BITS-1:0] wr_addr_wide;
    logic [ADDR_BITS+RANGE_BITS-1:0] rd_addr_wide;

    // Midpoint of the live range, rounded down.
    logic [RANGE_BITS:0]       mid_sum;
    logic [RANGE_BITS-1:0]     mid_calc;
    logic [2*COUNT_BITS-1:0]   range_product;

    // One restoring divider step.
    logic [COUNT_BITS:0]       div_shift;
    logic                      div_fits;

    assign mid_sum       = {1'b0, lo_reg} + {1'b0, end_reg} - (RANGE_BITS+1)'(1);
    assign mid_calc      = mid_sum[RANGE_BITS:1];
    assign range_product = rows_eff * cols_eff;

    assign rd_addr_wide  = {{ADDR_BITS{1'b0}}, mid_calc};
    assign rd_addr       = rd_addr_wide[ADDR_BITS-1:0];
    assign wr_addr_wide  = {{ADDR_BITS{1'b0}}, in_index};
    assign wr_addr       = wr_addr_wide[ADDR_BITS-1:0];
    assign wr_en         = in_accept && (in_op == OP_LOAD) && (32'(in_index) < 32'(DEPTH));

    assign div_shift     = {rem_reg, quo_reg[RANGE_BITS-1]};
    assign div_fits      = div_shift >= {1'b0, cols_reg};

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        end_next       = end_reg;
        mid_next       = mid_reg;
        cols_next      = cols_reg;
        hit_next       = hit_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_op == OP_SEARCH))
                begin
                    key_next   = in_value;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                lo_next    = '0;
                end_next   = range_product;
                cols_next  = cols_eff;
                hit_next   = 1'b0;
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                // The read of the midpoint is issued here; the data lands next cycle.
                if (lo_reg < end_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = ST_COMPARE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_COMPARE:
            begin
                if (rd_data_reg == key_reg)
                begin
                    hit_next     = 1'b1;
                    quo_next     = mid_reg;
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIVIDE;
                end
                else
                begin
                    if ($signed(rd_data_reg) < $signed(key_reg))
                    begin
                        lo_next = mid_reg + RANGE_BITS'(1);
                    end
                    else
                    begin
                        end_next = mid_reg;
                    end
                    state_next = ST_PROBE;
                end
            end
            ST_DIVIDE:
            begin
                // One quotient bit per cycle; the remainder stays below the divisor.
                if (div_fits)
                begin
                    rem_next = COUNT_BITS'(div_shift - {1'b0, cols_reg});
                end
                else
                begin
                    rem_next = div_shift[COUNT_BITS-1:0];
                end
                quo_next     = {quo_reg[RANGE_BITS-2:0], div_fits};
                div_cnt_next = div_cnt_reg + DIV_COUNT_BITS'(1);
                if (div_cnt_reg == DIV_COUNT_BITS'(RANGE_BITS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = hit_reg;
                    out_row_next   = hit_reg ? quo_reg[POS_BITS-1:0] : '0;
                    out_col_next   = hit_reg ? rem_reg[POS_BITS-1:0] : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            row_count_reg    <= COUNT_BITS'(1);
            column_count_reg <= COUNT_BITS'(1);
            out_valid_reg    <= 1'b0;
            div_cnt_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            out_valid_reg    <= out_valid_next;
            div_cnt_reg      <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        end_reg       <= end_next;
        mid_reg       <= mid_next;
        cols_reg      <= cols_next;
        hit_reg       <= hit_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        out_found_reg <= out_found_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
    end

    // Element store: one write port for loads, one registered read port for probes.
    // Loads and searches never overlap, since a search holds off the input stream.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-2*POS_BITS){1'b0}}, out_col_reg, out_row_reg};

endmodule

`default_nettype wire

// ----- test/flat_binary_search_matrix_tb.sv -----
// Self-checking testbench for the flat binary search matrix: directed table, then random phases.
module flat_binary_search_matrix_tb
    import fbsm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Clock period, the settle pause before register writes and at the end, and the run limit.
    // The settle pause is longer than the slowest search, so it covers any work still in flight.
    localparam int CLK_PERIOD    = 8;
    localparam int SETTLE_CYCLES = 64;
    localparam int LIMIT_CYCLES  = 800_000;

    // The run stops adding phases after this many accepted input beats. Both sides stop
    // idling once the tail threshold is passed.
    localparam int ITEM_GOAL  = 1700;
    localparam int TAIL_START = 1500;

    // Register indexes the block does not implement; writes to them must be ignored.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_3 = 2'd3;

    localparam logic [ITEM_BITS-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [ITEM_BITS-1:0] INT_MAX = 32'h7FFF_FFFF;

    // One search result: found flag plus the row and column of the match.
    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
    } match_t;

    localparam match_t HIT_ORIGIN = '{1'b1, 5'd0, 5'd0};
    localparam match_t NO_HIT     = '{1'b0, 5'd0, 5'd0};

    // How a random phase fills the matrix range before it searches it.
    typedef enum logic [1:0] {
        FILL_SORTED,
        FILL_DUPLICATES,
        FILL_SCRAMBLED,
        FILL_KEEP
    } fill_mode_t;

    // One row of the directed table: either a register write or an input beat. A search
    // row with a typed result is checked against that value instead of the predictor.
    typedef struct {
        bit                        is_cfg;
        logic [CFG_INDEX_BITS-1:0] cfg_idx;
        logic [COUNT_BITS-1:0]     cfg_val;
        logic                      op;
        logic [INDEX_BITS-1:0]     idx;
        logic [ITEM_BITS-1:0]      val;
        bit                        typed;
        match_t                    hit;
    } dir_row_t;

    localparam int DIRECTED_ROWS = 22;

    // After reset both counts are one, so every search here probes at most entry 0.
    dir_row_t directed_plan [DIRECTED_ROWS] = '{
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_LOAD,   10'd0,    INT_MIN,      1'b0, NO_HIT},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_SEARCH, 10'd0,    INT_MIN,      1'b1, HIT_ORIGIN},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_SEARCH, 10'd0,    INT_MAX,      1'b1, NO_HIT},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_SEARCH, 10'd0,    32'd0,        1'b1, NO_HIT},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_LOAD,   10'd1023, 32'hFFFF_FFFF, 1'b0, NO_HIT},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_LOAD,   10'd0,    INT_MAX,      1'b0, NO_HIT},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_SEARCH, 10'd1023, INT_MAX,      1'b1, HIT_ORIGIN},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_SEARCH, 10'd0,    INT_MIN,      1'b1, NO_HIT},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_LOAD,   10'd0,    32'h5555_5555, 1'b0, NO_HIT},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_SEARCH, 10'd682,  32'h5555_5555, 1'b1, HIT_ORIGIN},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_SEARCH, 10'd341,  32'hAAAA_AAAA, 1'b0, NO_HIT},
        // A zero column count empties the range.
        '{1'b1, CFG_COLUMN_COUNT, 6'd0,  OP_LOAD,   10'd0,    32'd0,        1'b0, NO_HIT},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_SEARCH, 10'd0,    32'h5555_5555, 1'b1, NO_HIT},
        // A zero row count does the same.
        '{1'b1, CFG_ROW_COUNT,    6'd0,  OP_LOAD,   10'd0,    32'd0,        1'b0, NO_HIT},
        '{1'b1, CFG_COLUMN_COUNT, 6'd1,  OP_LOAD,   10'd0,    32'd0,        1'b0, NO_HIT},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_SEARCH, 10'd0,    32'h5555_5555, 1'b1, NO_HIT},
        // Writes to unknown indexes must leave both counts alone.
        '{1'b1, CFG_UNUSED_2,     6'd1,  OP_LOAD,   10'd0,    32'd0,        1'b0, NO_HIT},
        '{1'b1, CFG_UNUSED_3,     6'd63, OP_LOAD,   10'd0,    32'd0,        1'b0, NO_HIT},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_SEARCH, 10'd0,    32'h5555_5555, 1'b1, NO_HIT},
        '{1'b1, CFG_ROW_COUNT,    6'd1,  OP_LOAD,   10'd0,    32'd0,        1'b0, NO_HIT},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_SEARCH, 10'd0,    32'h5555_5555, 1'b1, HIT_ORIGIN},
        '{1'b0, CFG_ROW_COUNT,    6'd0,  OP_SEARCH, 10'd0,    32'h5555_5554, 1'b0, NO_HIT}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_DATA_BITS-1:0]   s_axis_tdata;   // Bits 9:0 element_index, 41:10 item_value.
    logic                      s_axis_tuser;   // Bit 0 operation.
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;   // Bits 4:0 match_row, 9:5 match_column.
    logic                      m_axis_tuser;   // Bit 0 found.
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [COUNT_BITS-1:0]     cfg_data;

    // Predictor state: a copy of the element store and of both count registers, updated
    // at the clock edge where the matching beat or register write is accepted.
    logic signed [ITEM_BITS-1:0] matrix_copy [DEF_MAX_ROWS * DEF_MAX_COLUMNS];
    logic [COUNT_BITS-1:0]       rows_copy;
    logic [COUNT_BITS-1:0]       cols_copy;

    // Results still owed by the block, oldest first.
    match_t pending_hits [$];

    int mismatches  = 0;
    int items_sent  = 0;
    bit tail_quiet  = 1'b0;
    bit idle_on     = 1'b1;
    bit stall_on    = 1'b1;

    flat_binary_search_matrix dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Counts above the matrix bound are taken as the bound.
    function automatic int clamp_count(input logic [COUNT_BITS-1:0] count, input int bound);
        return (int'(count) > bound) ? bound : int'(count);
    endfunction

    // Inclusive-bounds binary search with the midpoint rounded down, over the flat range
    // given by the current counts. The first probe that equals the key is the match.
    function automatic match_t locate_key(input logic signed [ITEM_BITS-1:0] key);
        int     rows;
        int     cols;
        int     lo;
        int     hi;
        int     mid;
        match_t hit;
        hit  = NO_HIT;
        rows = clamp_count(rows_copy, DEF_MAX_ROWS);
        cols = clamp_count(cols_copy, DEF_MAX_COLUMNS);
        if (rows == 0 || cols == 0)
        begin
            return hit;
        end
        lo = 0;
        hi = rows * cols - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (matrix_copy[mid] == key)
            begin
                hit.found = 1'b1;
                hit.row   = POS_BITS'(mid / cols);
                hit.col   = POS_BITS'(mid % cols);
                return hit;
            end
            if (matrix_copy[mid] < key)
            begin
                lo = mid + 1;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        return hit;
    endfunction

    // Mostly small counts, with zero, the bound and values above the bound now and then.
    function automatic logic [COUNT_BITS-1:0] pick_count();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
        begin
            return '0;
        end
        if (sel == 1)
        begin
            return COUNT_BITS'($urandom_range(33, 63));
        end
        if (sel == 2)
        begin
            return COUNT_BITS'(32);
        end
        return COUNT_BITS'($urandom_range(1, 6));
    endfunction

    // Sends one input beat, with an optional idle burst in front of it. Valid stays high
    // after the accepting edge, so a following beat goes out back to back. The predictor
    // sees the beat at the accepting edge, which keeps it in the block's own order.
    task automatic push_beat(input logic op, input logic [INDEX_BITS-1:0] idx,
                             input logic [ITEM_BITS-1:0] val, input bit typed,
                             input match_t typed_hit);
        if (idle_on && !tail_quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_BITS'({val, idx});
        s_axis_tuser  <= op;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        if (op == OP_LOAD)
        begin
            matrix_copy[idx] = val;
        end
        else
        begin
            pending_hits.push_back(typed ? typed_hit : locate_key(val));
        end
        items_sent++;
        if (items_sent >= TAIL_START)
        begin
            tail_quiet = 1'b1;
        end
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_hits.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Register writes happen only with the block idle: drained, then a settle pause, since
    // a trailing load leaves no result to wait for.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [COUNT_BITS-1:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == CFG_ROW_COUNT)
        begin
            rows_copy = data;
        end
        else if (idx == CFG_COLUMN_COUNT)
        begin
            cols_copy = data;
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: checks every accepted beat against the oldest owed result, then decides
    // the ready level for the next cycle. Stalls come in bursts.
    initial
    begin
        match_t want;
        int     stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_hits.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result beat with no search pending: found=%0b row=%0d col=%0d",
                                 m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[9:5]);
                    end
                end
                else
                begin
                    want = pending_hits.pop_front();
                    if (m_axis_tuser !== want.found || m_axis_tdata[4:0] !== want.row ||
                        m_axis_tdata[9:5] !== want.col)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: expected found=%0b row=%0d col=%0d",
                                     want.found, want.row, want.col);
                            $display("          got      found=%0b row=%0d col=%0d",
                                     m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[9:5]);
                        end
                    end
                end
            end
            if (tail_quiet || !stall_on)
            begin
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus: reset, the directed table, then random phases. Each phase sets both counts,
    // fills the flat range in full or in part, or keeps it, and runs searches with the odd stray load mixed in.
    initial
    begin
        int                    phase;
        int                    n;
        int                    searches;
        int                    pick;
        int                    probe_idx;
        int                    base;
        int                    vals [$];
        logic [COUNT_BITS-1:0] rows_sel;
        logic [COUNT_BITS-1:0] cols_sel;
        logic [ITEM_BITS-1:0]  key;
        fill_mode_t            mode;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_LOAD;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_ROW_COUNT;
        cfg_data      <= '0;
        rows_copy      = COUNT_BITS'(1);
        cols_copy      = COUNT_BITS'(1);
        foreach (matrix_copy[i])
        begin
            matrix_copy[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_plan[r].is_cfg)
            begin
                write_register(directed_plan[r].cfg_idx, directed_plan[r].cfg_val);
            end
            else
            begin
                push_beat(directed_plan[r].op, directed_plan[r].idx, directed_plan[r].val,
                          directed_plan[r].typed, directed_plan[r].hit);
            end
        end

        // The first phase fills the whole store at the largest size, so that no later
        // search can reach an entry that was never written. The second runs with both
        // counts past the bound over the same contents, apart from stray loads.
        phase = 0;
        while (items_sent < ITEM_GOAL)
        begin
            if (phase == 0)
            begin
                rows_sel = COUNT_BITS'(32);
                cols_sel = COUNT_BITS'(32);
                mode     = FILL_SORTED;
            end
            else if (phase == 1)
            begin
                rows_sel = COUNT_BITS'(63);
                cols_sel = COUNT_BITS'(63);
                mode     = FILL_KEEP;
            end
            else
            begin
                rows_sel = pick_count();
                cols_sel = pick_count();
                pick     = $urandom_range(0, 9);
                mode     = (pick < 5) ? FILL_SORTED : (pick < 7) ? FILL_DUPLICATES :
                           (pick < 8) ? FILL_SCRAMBLED : FILL_KEEP;
            end
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);

            if ($urandom_range(0, 1) == 0)
            begin
                write_register(CFG_ROW_COUNT, rows_sel);
                write_register(CFG_COLUMN_COUNT, cols_sel);
            end
            else
            begin
                write_register(CFG_COLUMN_COUNT, cols_sel);
                write_register(CFG_ROW_COUNT, rows_sel);
            end
            n = clamp_count(rows_sel, DEF_MAX_ROWS) * clamp_count(cols_sel, DEF_MAX_COLUMNS);

            if (n > 0)
            begin
                case (mode)
                    FILL_SORTED, FILL_DUPLICATES:
                    begin
                        // Narrow spread gives runs of equal elements.
                        vals.delete();
                        base = $urandom;
                        for (int i = 0; i < n; i++)
                        begin
                            vals.push_back((mode == FILL_SORTED) ? int'($urandom) :
                                           base + int'($urandom_range(0, n / 4)));
                        end
                        vals.sort();
                        if ($urandom_range(0, 2) == 0)
                        begin
                            vals[0]     = int'(INT_MIN);
                            vals[n - 1] = int'(INT_MAX);
                        end
                        for (int i = 0; i < n; i++)
                        begin
                            push_beat(OP_LOAD, INDEX_BITS'(i), vals[i], 1'b0, NO_HIT);
                        end
                    end
                    FILL_SCRAMBLED:
                    begin
                        // Unsorted contents: the search still follows its fixed probes.
                        for (int i = 0; i < ((n < 40) ? n : 40); i++)
                        begin
                            push_beat(OP_LOAD, INDEX_BITS'($urandom_range(0, n - 1)),
                                      $urandom, 1'b0, NO_HIT);
                        end
                    end
                    default:
                    begin
                        for (int i = 0; i < $urandom_range(0, 3); i++)
                        begin
                            push_beat(OP_LOAD, INDEX_BITS'($urandom_range(0, n - 1)),
                                      $urandom, 1'b0, NO_HIT);
                        end
                    end
                endcase
            end

            searches = $urandom_range(8, 30);
            for (int s = 0; s < searches; s++)
            begin
                if ((phase == 1 && s == 0) || $urandom_range(0, 39) == 0)
                begin
                    wait_drained();
                end
                if ($urandom_range(0, 11) == 0)
                begin
                    push_beat(OP_LOAD, INDEX_BITS'($urandom), $urandom, 1'b0, NO_HIT);
                end
                // Keys: present elements in half the picks, some neighbors of them, the extremes,
                // and fully random values.
                pick      = $urandom_range(0, 9);
                probe_idx = (n > 0) ? $urandom_range(0, n - 1) : 0;
                if (n > 0 && pick < 5)
                begin
                    key = matrix_copy[probe_idx];
                end
                else if (n > 0 && pick < 7)
                begin
                    key = matrix_copy[probe_idx] + ((pick == 5) ? 32'd1 : 32'hFFFF_FFFF);
                end
                else if (pick == 7)
                begin
                    key = $urandom_range(0, 1) ? INT_MIN : INT_MAX;
                end
                else
                begin
                    key = $urandom;
                end
                push_beat(OP_SEARCH, INDEX_BITS'($urandom), key, 1'b0, NO_HIT);
            end
            phase++;
        end

        // Drain, then give the block time to show any stray result.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_hits.size() == 0)
        begin
            $display("flat_binary_search_matrix_tb: PASS");
        end
        else
        begin
            $display("flat_binary_search_matrix_tb: FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("flat_binary_search_matrix_tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
src/fbsm_pkg.sv
src/flat_binary_search_matrix.sv
test/flat_binary_search_matrix_tb.sv
